[rtl/core/sdrp_pkg.sv]
package sdrp_pkg;

  // response storage
  localparam int MAX_RESPONSE_BYTES = 5;
  localparam int BYTE_IDX_W         = $clog2(MAX_RESPONSE_BYTES);
  localparam int BYTE_COUNT_W       = 3;

  // expected response kinds
  localparam logic [1:0] RESP_R1 = 2'd0;
  localparam logic [1:0] RESP_R2 = 2'd1;
  localparam logic [1:0] RESP_R3 = 2'd2;
  localparam logic [1:0] RESP_R7 = 2'd3;

  // byte masks
  localparam logic [7:0] BUSY_BIT    = 8'h80;
  localparam logic [7:0] R1_ERR_MASK = 8'h7C;
  localparam logic [7:0] R2_ERR_MASK = 8'hBC;
  localparam logic [7:0] NIBBLE_HI   = 8'hF0;
  localparam logic [7:0] NIBBLE_LO   = 8'h0F;

  // response lengths in bytes, r3 and r7 share the long form
  localparam logic [BYTE_COUNT_W-1:0] LEN_SHORT_BYTES = 3'd1;
  localparam logic [BYTE_COUNT_W-1:0] LEN_STATUS_BYTES = 3'd2;
  localparam logic [BYTE_COUNT_W-1:0] LEN_LONG_BYTES  = 3'd5;

  typedef logic [MAX_RESPONSE_BYTES-1:0][7:0] resp_bytes_t;

  typedef struct packed {
    logic        timed_out;
    logic        error;
    logic [7:0]  r1_status;
    logic [7:0]  r2_status;
    logic [31:0] ocr;
    logic [3:0]  cmd_version;
    logic [3:0]  voltage_accepted;
    logic [7:0]  check_pattern;
  } result_t;

  // bytes in a response of the given kind
  function automatic logic [BYTE_COUNT_W-1:0] resp_len(input logic [1:0] kind);
    logic [BYTE_COUNT_W-1:0] len;
    unique case (kind)
      RESP_R1: len = LEN_SHORT_BYTES;
      RESP_R2: len = LEN_STATUS_BYTES;
      RESP_R3: len = LEN_LONG_BYTES;
      RESP_R7: len = LEN_LONG_BYTES;
      default: len = LEN_SHORT_BYTES;
    endcase
    return len;
  endfunction

endpackage

[rtl/core/sd_spi_response_parser.sv]
// an accepted item is held in the input register, its result in the output register
// throughput: one input item per cycle while results are taken; a waiting result
// stalls the input once the input register holds one item
// reset: synchronous active-high rst clears control state, wait limit returns to 4
// stored response bytes are not reset and are always written before use
module sd_spi_response_parser
  import sdrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,     // response_wait_limit
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // rx_byte
  input  logic [2:0]  s_tuser,      // begin_req, resp_type[1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,      // error, r1_status, r2_status, ocr, cmd_version,
                                    // voltage_accepted, check_pattern, zero pad
  output logic        m_tuser       // timed_out
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_WAIT    = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  logic [7:0]              limit;
  logic                    in_valid;
  logic                    in_begin;
  logic [1:0]              in_type;
  logic [7:0]              in_byte;
  logic [1:0]              phase, phase_next;
  logic [7:0]              wait_count, wait_count_next;
  logic [BYTE_COUNT_W-1:0] byte_count, byte_count_next;
  logic [1:0]              held_type, held_type_next;
  resp_bytes_t             resp_bytes, merged;
  logic                    wr_en;
  logic [BYTE_IDX_W-1:0]   wr_idx;
  logic                    emit, emit_timeout;
  logic                    advance;
  logic                    out_valid;
  result_t                 out_res, done_res, step_res;
  logic [1:0]              eff_phase;
  logic [7:0]              eff_wait;
  logic [BYTE_COUNT_W-1:0] eff_count, len;
  logic [8:0]              wait_inc;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 8'd4;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // handshake
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_begin <= s_tuser[0];
      in_type  <= s_tuser[2:1];
      in_byte  <= s_tdata;
    end
  end

  // begin restarts the response with this byte
  always_comb begin
    held_type_next = in_begin ? in_type : held_type;
    eff_phase      = in_begin ? PH_WAIT : phase;
    eff_wait       = in_begin ? 8'd0 : wait_count;
    eff_count      = in_begin ? '0 : byte_count;
  end

  assign len      = resp_len(held_type_next);
  assign wait_inc = {1'b0, eff_wait} + 9'd1;

  // parser step
  always_comb begin
    phase_next      = eff_phase;
    wait_count_next = eff_wait;
    byte_count_next = eff_count;
    wr_en           = 1'b0;
    wr_idx          = '0;
    emit            = 1'b0;
    emit_timeout    = 1'b0;
    unique case (eff_phase)
      PH_WAIT: begin
        if ((in_byte & BUSY_BIT) != 8'h00) begin
          if (wait_inc >= {1'b0, limit}) begin
            phase_next      = PH_IDLE;
            wait_count_next = 8'd0;
            emit            = 1'b1;
            emit_timeout    = 1'b1;
          end else begin
            wait_count_next = wait_inc[7:0];
          end
        end else begin
          wr_en           = 1'b1;
          byte_count_next = BYTE_COUNT_W'(1);
          if (BYTE_COUNT_W'(1) >= len) begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
          end else begin
            phase_next = PH_COLLECT;
          end
        end
      end
      PH_COLLECT: begin
        wr_en           = {1'b0, eff_count} < (BYTE_COUNT_W + 1)'(MAX_RESPONSE_BYTES);
        wr_idx          = eff_count[BYTE_IDX_W-1:0];
        byte_count_next = eff_count + BYTE_COUNT_W'(1);
        if (byte_count_next >= len) begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // stored bytes with this item's byte in place
  always_comb begin
    for (int i = 0; i < MAX_RESPONSE_BYTES; i++) begin
      merged[i] = (wr_en && (wr_idx == BYTE_IDX_W'(i))) ? in_byte : resp_bytes[i];
    end
  end

  sdrp_decode u_decode (
    .bytes     (merged),
    .held_type (held_type_next),
    .res       (done_res)
  );

  // timeout result carries only the two flags
  always_comb begin
    step_res = done_res;
    if (emit_timeout) begin
      step_res           = '0;
      step_res.timed_out = 1'b1;
      step_res.error     = 1'b1;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= 8'd0;
      byte_count <= '0;
      held_type  <= RESP_R1;
    end else if (advance) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      byte_count <= byte_count_next;
      held_type  <= held_type_next;
    end
  end

  // response byte store
  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      resp_bytes[wr_idx] <= in_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.timed_out;
  assign m_tdata  = {7'd0, out_res.check_pattern, out_res.voltage_accepted,
                     out_res.cmd_version, out_res.ocr, out_res.r2_status,
                     out_res.r1_status, out_res.error};

`ifndef SYNTH
  // a new result only appears after an item was processed
  a_out_from_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a processed item");

  // timeout result has error set and r1 cleared
  a_timeout_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.timed_out |-> out_res.error && (out_res.r1_status == 8'd0))
    else $error("timeout result fields wrong");

  // collecting never runs past the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_COLLECT |-> {1'b0, byte_count} < (BYTE_COUNT_W + 1)'(MAX_RESPONSE_BYTES))
    else $error("byte count beyond response length");

  // a stalled result is not overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(out_res))
    else $error("pending result lost");

  // a finished response leaves the parser idle
  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> phase == PH_IDLE)
    else $error("parser not idle after result");
`endif

endmodule

[rtl/core/sdrp_decode.sv]
module sdrp_decode
  import sdrp_pkg::*;
(
  input  resp_bytes_t bytes,
  input  logic [1:0]  held_type,
  output result_t     res
);

  logic r1_err;

  assign r1_err = (bytes[0] & R1_ERR_MASK) != 8'h00;

  // field extraction for a completed response
  always_comb begin
    res           = '0;
    res.r1_status = bytes[0];
    res.error     = r1_err;
    unique case (held_type)
      RESP_R2: begin
        res.r2_status = bytes[1];
        if ((bytes[1] & R2_ERR_MASK) != 8'h00) res.error = 1'b1;
      end
      RESP_R3: begin
        if (!r1_err) res.ocr = {bytes[1], bytes[2], bytes[3], bytes[4]};
      end
      RESP_R7: begin
        if (!r1_err) begin
          res.cmd_version      = 4'((bytes[1] & NIBBLE_HI) >> 4);
          res.voltage_accepted = 4'(bytes[3] & NIBBLE_LO);
          res.check_pattern    = bytes[4];
        end
      end
      default: ;
    endcase
  end

endmodule

[verif/sd_spi_response_parser_test.sv]
`timescale 1ns / 1ps

import sdrp_pkg::*;

// parser progress through one response
typedef enum logic [1:0] {
  PH_IDLE,
  PH_WAIT,
  PH_COLLECT
} parse_state_t;

// bytes that make up a response of the given kind, r1 byte included
function automatic int bytes_in(input logic [1:0] rtype);
  case (rtype)
    RESP_R1: return 1;
    RESP_R2: return 2;
    default: return 5;
  endcase
endfunction

// tracks the card byte stream and holds the responses still to come out
class resp_scoreboard;
  logic [7:0]   wait_limit;
  parse_state_t state;
  logic [7:0]   busy_seen;
  logic [2:0]   got_bytes;
  logic [1:0]   kind;
  logic [7:0]   resp_byte [MAX_RESPONSE_BYTES];
  result_t      expected_q[$];
  int           fails;

  function new();
    wait_limit = 8'd4;
    state      = PH_IDLE;
    busy_seen  = '0;
    got_bytes  = '0;
    kind       = RESP_R1;
    fails      = 0;
    foreach (resp_byte[i]) resp_byte[i] = '0;
  endfunction

  // decode the collected bytes into one response
  function void close_response();
    result_t res;
    logic    r1_bad;
    res           = '0;
    r1_bad        = |(resp_byte[0] & R1_ERR_MASK);
    res.r1_status = resp_byte[0];
    res.error     = r1_bad;
    state         = PH_IDLE;
    case (kind)
      RESP_R2: begin
        res.r2_status = resp_byte[1];
        if (|(resp_byte[1] & R2_ERR_MASK)) res.error = 1'b1;
      end
      RESP_R3: begin
        if (!r1_bad) res.ocr = {resp_byte[1], resp_byte[2], resp_byte[3], resp_byte[4]};
      end
      RESP_R7: begin
        if (!r1_bad) begin
          res.cmd_version      = resp_byte[1][7:4];
          res.voltage_accepted = resp_byte[3][3:0];
          res.check_pattern    = resp_byte[4];
        end
      end
      default: ;
    endcase
    expected_q.push_back(res);
  endfunction

  // accepted input item; returns 0 when the parser ignores it
  function bit note_item(input logic start, input logic [1:0] rtype, input logic [7:0] data);
    result_t res;
    res = '0;
    if (start) begin
      kind      = rtype;
      busy_seen = '0;
      got_bytes = '0;
      state     = PH_WAIT;
    end else if (state == PH_IDLE) begin
      return 1'b0;
    end
    // waiting for the r1 byte, busy bytes count toward the timeout
    if (state == PH_WAIT) begin
      if (data & BUSY_BIT) begin
        if (({1'b0, busy_seen} + 9'd1) >= {1'b0, wait_limit}) begin
          state         = PH_IDLE;
          busy_seen     = '0;
          res.timed_out = 1'b1;
          res.error     = 1'b1;
          expected_q.push_back(res);
        end else begin
          busy_seen = busy_seen + 8'd1;
        end
        return 1'b1;
      end
      resp_byte[0] = data;
      got_bytes    = 3'd1;
      if (got_bytes >= bytes_in(kind)) close_response();
      else state = PH_COLLECT;
      return 1'b1;
    end
    // collecting, bit 7 is plain data here
    if (got_bytes < MAX_RESPONSE_BYTES) resp_byte[got_bytes] = data;
    got_bytes = got_bytes + 3'd1;
    if (got_bytes >= bytes_in(kind)) close_response();
    return 1'b1;
  endfunction

  function void compare(input string field, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      fails++;
    end
  endfunction

  // accepted result item against the oldest pending response
  function void check_result(input result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result item, expected none, got %h", $time, got);
      fails++;
      return;
    end
    want = expected_q.pop_front();
    compare("timed_out", 32'(want.timed_out), 32'(got.timed_out));
    compare("error", 32'(want.error), 32'(got.error));
    compare("r1_status", 32'(want.r1_status), 32'(got.r1_status));
    compare("r2_status", 32'(want.r2_status), 32'(got.r2_status));
    compare("ocr", want.ocr, got.ocr);
    compare("cmd_version", 32'(want.cmd_version), 32'(got.cmd_version));
    compare("voltage_accepted", 32'(want.voltage_accepted), 32'(got.voltage_accepted));
    compare("check_pattern", 32'(want.check_pattern), 32'(got.check_pattern));
  endfunction
endclass

module sd_spi_response_parser_test;

  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;    // rx_byte
  logic [2:0]  s_tuser   = '0;    // begin_req, resp_type[1:0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [71:0] m_tdata;           // error, r1_status, r2_status, ocr, cmd_version,
                                  // voltage_accepted, check_pattern, zero pad
  logic        m_tuser;           // timed_out

  resp_scoreboard sb;
  int  live_items  = 0;
  int  idle_cycles = 0;
  bit  tx_gaps_on  = 1'b1;
  bit  rx_stall_on = 1'b1;
  bit  sink_hold   = 1'b0;

  sd_spi_response_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one card byte, with a random gap in front
  task automatic send_item(input logic start, input logic [1:0] rtype, input logic [7:0] data);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= {rtype, start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (sb.note_item(start, rtype, data)) live_items++;
  endtask

  // busy bytes, then the first keep bytes of the response
  task automatic send_response(input logic [1:0] rtype, input int nbusy, input logic [7:0] r1,
                               input int keep);
    int         i;
    logic [7:0] b;
    for (i = 0; i < nbusy; i++)
      send_item(i == 0, rtype, BUSY_BIT | 8'($urandom_range(0, 127)));
    if (keep == 0) return;
    send_item(nbusy == 0, rtype, r1);
    for (i = 1; i < keep; i++) begin
      b = 8'($urandom_range(0, 255));
      if (rtype == RESP_R2 && $urandom_range(0, 1) == 1) b = b & ~R2_ERR_MASK;
      send_item(1'b0, rtype, b);
    end
  endtask

  // new wait limit once everything in flight has come out
  task automatic write_limit(input logic [7:0] value);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid     <= 1'b0;
    sb.wait_limit = value;
  endtask

  // mostly well-formed responses, some timeouts, truncated responses and noise
  task automatic random_traffic(input int n_items);
    int         target;
    int         pick;
    int         lim;
    int         nbusy;
    int         len;
    int         k;
    logic [1:0] rtype;
    logic [7:0] r1;
    target = live_items + n_items;
    lim    = (sb.wait_limit == 0) ? 1 : int'(sb.wait_limit);
    while (live_items < target) begin
      if ($urandom_range(0, 15) == 0) tx_gaps_on = !tx_gaps_on;
      pick  = $urandom_range(0, 19);
      rtype = 2'($urandom_range(0, 3));
      len   = bytes_in(rtype);
      r1    = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 127))
                                          : 8'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) nbusy = $urandom_range(0, lim - 1);
      else nbusy = $urandom_range(0, (lim - 1 < 3) ? lim - 1 : 3);
      if (pick < 2) begin
        k = $urandom_range(1, 6);
        repeat (k)
          send_item($urandom_range(0, 3) == 0, 2'($urandom_range(0, 3)),
                    8'($urandom_range(0, 255)));
      end else if (pick < 4) begin
        if (lim <= 16 || $urandom_range(0, 7) == 0) send_response(rtype, lim, r1, 0);
      end else if (pick < 6) begin
        send_response(rtype, nbusy, r1, $urandom_range(0, len - 1));
      end else begin
        send_response(rtype, nbusy, r1, len);
      end
    end
    // leave the parser idle
    send_item(1'b1, RESP_R1, 8'($urandom_range(0, 3)));
  endtask

  // result side, random stalls and one long hold on request
  initial begin : sink
    int gap;
    forever begin
      if ($urandom_range(0, 31) == 0) rx_stall_on = !rx_stall_on;
      gap = rx_stall_on ? $urandom_range(0, 15) : 0;
      if (sink_hold) begin
        gap       = HOLD_CYCLES;
        sink_hold = 1'b0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    result_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen.error            = m_tdata[0];
      seen.r1_status        = m_tdata[8:1];
      seen.r2_status        = m_tdata[16:9];
      seen.ocr              = m_tdata[48:17];
      seen.cmd_version      = m_tdata[52:49];
      seen.voltage_accepted = m_tdata[56:53];
      seen.check_pattern    = m_tdata[64:57];
      seen.timed_out        = m_tuser;
      sb.check_result(seen);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: byte while idle is ignored
    send_item(1'b0, RESP_R7, 8'hFF);
    // plain r1
    send_item(1'b1, RESP_R1, 8'h00);
    // r2 with every status bit set
    send_item(1'b1, RESP_R2, 8'h01);
    send_item(1'b0, RESP_R2, 8'hFF);
    // r3 after one busy byte
    send_item(1'b1, RESP_R3, 8'h80);
    send_item(1'b0, RESP_R3, 8'h01);
    send_item(1'b0, RESP_R3, 8'hFF);
    send_item(1'b0, RESP_R3, 8'h00);
    send_item(1'b0, RESP_R3, 8'hAA);
    send_item(1'b0, RESP_R3, 8'h55);
    // r7 with an r1 error, fields blanked
    send_item(1'b1, RESP_R7, 8'h04);
    send_item(1'b0, RESP_R7, 8'h12);
    send_item(1'b0, RESP_R7, 8'h34);
    send_item(1'b0, RESP_R7, 8'h56);
    send_item(1'b0, RESP_R7, 8'h78);
    // clean r7, busy bit inside the data
    send_item(1'b1, RESP_R7, 8'h01);
    send_item(1'b0, RESP_R7, 8'hA5);
    send_item(1'b0, RESP_R7, 8'h00);
    send_item(1'b0, RESP_R7, 8'h3C);
    send_item(1'b0, RESP_R7, 8'hC3);
    // timeout at the reset limit
    send_item(1'b1, RESP_R1, 8'hFF);
    send_item(1'b0, RESP_R1, 8'h80);
    send_item(1'b0, RESP_R1, 8'h81);
    send_item(1'b0, RESP_R1, 8'hFE);
    // new command aborts an r3 halfway
    send_item(1'b1, RESP_R3, 8'h00);
    send_item(1'b0, RESP_R3, 8'h11);
    send_item(1'b1, RESP_R1, 8'h7F);

    // back-to-back r1 responses against a held result side
    sink_hold  = 1'b1;
    tx_gaps_on = 1'b0;
    repeat (40) send_item(1'b1, RESP_R1, 8'($urandom_range(0, 127)));
    tx_gaps_on = 1'b1;

    random_traffic(250);
    write_limit(8'd1);
    random_traffic(250);
    write_limit(8'd255);
    random_traffic(250);
    write_limit(8'd2);
    random_traffic(250);
    write_limit(8'($urandom_range(3, 20)));
    random_traffic(250);
    write_limit(8'($urandom_range(1, 255)));
    random_traffic(250);
    write_limit(8'd4);
    random_traffic(250);

    // drain
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
